// ----- sv/bat_pkg.sv -----
// Package with the shared types, constants and divider step of the bearing unit.
package bat_pkg;

  localparam int DATA_W = 16;
  localparam int MAG_W = 15;
  localparam int QUO_W = 15;
  localparam int REM_W = 16;
  localparam int BITS_PER_STAGE = 3;
  localparam int DIV_STAGES = QUO_W / BITS_PER_STAGE;
  localparam int Q_SHIFT = 14;

  localparam logic [13:0] ATAN_C0 = 14'h2800;
  localparam logic [14:0] ATAN_MID = 15'h1333;
  localparam logic [11:0] ATAN_K = 12'hB00;

  localparam logic [1:0] IDX_EAST = 2'd0;
  localparam logic [1:0] IDX_SOUTH = 2'd1;
  localparam logic [1:0] IDX_WEST = 2'd2;

  localparam logic [15:0] EAST_RESET = 16'd16384;
  localparam logic [15:0] SOUTH_RESET = 16'd32768;
  localparam logic [15:0] WEST_RESET = 16'd49152;

  // Kinds of axis-aligned offsets that bypass the arctangent path.
  localparam logic [1:0] KIND_NORTH = 2'd0;
  localparam logic [1:0] KIND_SOUTH = 2'd1;
  localparam logic [1:0] KIND_EAST = 2'd2;
  localparam logic [1:0] KIND_WEST = 2'd3;

  typedef struct packed {
    logic       axis;
    logic [1:0] kind;
    logic       swapped;
    logic       dx_neg;
    logic       dy_neg;
  } bat_ctl_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [MAG_W-1:0] den;
  } bat_div_t;

  typedef struct packed {
    logic [DATA_W-1:0] east;
    logic [DATA_W-1:0] south;
    logic [DATA_W-1:0] west;
  } bat_codes_t;

  // One restoring division step: one quotient bit, then the remainder doubles.
  function automatic bat_div_t div_step(bat_div_t d);
    bat_div_t r;
    r = d;
    if (d.rem >= {1'b0, d.den}) begin
      r.rem = d.rem - {1'b0, d.den};
      r.quo = {d.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.quo = {d.quo[QUO_W-2:0], 1'b0};
    end
    r.rem = {r.rem[REM_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

// ----- sv/bat_if.sv -----
// Valid/ready channel interfaces for the offset input and the bearing output.
interface bat_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  modport source(output valid, delta_x, delta_y, input ready);
  modport sink(input valid, delta_x, delta_y, output ready);
endinterface

interface bat_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bearing;
  modport source(output valid, bearing, input ready);
  modport sink(input valid, bearing, output ready);
endinterface

// ----- sv/bat_prep.sv -----
// First stage: saturation, magnitudes, axis detection and operand swap.
module bat_prep import bat_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               valid_in,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  output logic               valid,
  output bat_ctl_t           ctl,
  output bat_div_t           div
);

  logic signed [15:0] sx, sy;
  logic [MAG_W-1:0]   ax, ay;
  bat_ctl_t           ctl_next;
  bat_div_t           div_next;

  always_comb begin
    sx = (delta_x == 16'sh8000) ? -16'sd32767 : delta_x;
    sy = (delta_y == 16'sh8000) ? -16'sd32767 : delta_y;
    ax = sx[15] ? MAG_W'(-sx) : sx[MAG_W-1:0];
    ay = sy[15] ? MAG_W'(-sy) : sy[MAG_W-1:0];
    ctl_next.dx_neg = sx[15];
    ctl_next.dy_neg = sy[15];
    ctl_next.swapped = ax > ay;
    ctl_next.axis = (sx == 16'sd0) || (sy == 16'sd0);
    if (sx == 16'sd0) begin
      ctl_next.kind = (sy > 16'sd0) ? KIND_NORTH : KIND_SOUTH;
    end else begin
      ctl_next.kind = sx[15] ? KIND_WEST : KIND_EAST;
    end
    div_next.quo = '0;
    div_next.rem = {1'b0, ctl_next.swapped ? ay : ax};
    div_next.den = ctl_next.swapped ? ax : ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl <= ctl_next;
      div <= div_next;
    end
  end

endmodule

// ----- sv/bat_div_stage.sv -----
// One stage of the pipelined divider, producing three quotient bits.
module bat_div_stage import bat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     valid_in,
  input  bat_ctl_t ctl_in,
  input  bat_div_t div_in,
  output logic     valid,
  output bat_ctl_t ctl,
  output bat_div_t div
);

  bat_div_t div_next;

  always_comb begin
    div_next = div_in;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      div_next = div_step(div_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl <= ctl_in;
      div <= div_next;
    end
  end

endmodule

// ----- sv/bat_poly.sv -----
// Two multiply stages of the quadratic arctangent polynomial in Q14.
module bat_poly import bat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             valid_in,
  input  bat_ctl_t         ctl_in,
  input  logic [QUO_W-1:0] quo_in,
  output logic             valid,
  output bat_ctl_t         ctl,
  output logic [15:0]      angle
);

  logic [14:0]      diff;
  logic [26:0]      prod1_next;
  logic             valid1;
  bat_ctl_t         ctl1;
  logic [26:0]      prod1;
  logic [QUO_W-1:0] quo1;
  logic [13:0]      corr;
  logic [13:0]      coef;
  logic [28:0]      prod2;

  always_comb begin
    diff = (quo_in > ATAN_MID) ? quo_in - ATAN_MID : ATAN_MID - quo_in;
    prod1_next = 27'(diff) * 27'(ATAN_K);
    corr = {1'b0, prod1[26:Q_SHIFT]};
    coef = ATAN_C0 - corr;
    prod2 = 29'(coef) * 29'(quo1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid <= 1'b0;
    end else if (advance) begin
      valid1 <= valid_in;
      valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl1 <= ctl_in;
      prod1 <= prod1_next;
      quo1 <= quo_in;
      ctl <= ctl1;
      angle <= {1'b0, prod2[28:Q_SHIFT]};
    end
  end

endmodule

// ----- sv/bat_fold.sv -----
// Output stage: octant fold, axis answers and the output register.
module bat_fold import bat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        valid_in,
  input  bat_ctl_t    ctl_in,
  input  logic [15:0] angle,
  input  bat_codes_t  codes,
  output logic        valid,
  output logic [15:0] bearing
);

  logic [15:0] bearing_next;

  always_comb begin
    if (ctl_in.axis) begin
      case (ctl_in.kind)
        KIND_NORTH: bearing_next = 16'd0;
        KIND_SOUTH: bearing_next = codes.south;
        KIND_EAST:  bearing_next = codes.east;
        KIND_WEST:  bearing_next = codes.west;
        default:    bearing_next = 16'd0;
      endcase
    end else begin
      case ({ctl_in.dx_neg, ctl_in.dy_neg})
        2'b00:   bearing_next = ctl_in.swapped ? codes.east - angle : angle;
        2'b01:   bearing_next = ctl_in.swapped ? codes.east + angle : codes.south - angle;
        2'b10:   bearing_next = ctl_in.swapped ? codes.west + angle : 16'd0 - angle;
        2'b11:   bearing_next = ctl_in.swapped ? codes.west - angle : codes.south + angle;
        default: bearing_next = angle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bearing <= bearing_next;
    end
  end

endmodule

// ----- sv/fixed_point_bearing_atan2_unit.sv -----
// Top level of the fixed-point compass bearing unit.
// An accepted offset passes through the preparation stage, the divider, the polynomial multiplies and the fold stage.
// Throughput is one transaction per cycle; a stall on the output freezes every stage.
// The depth is set by the five-stage restoring divider plus the two polynomial multiplies.
// Reset is synchronous and active high; it empties the pipeline and restores the
// east, south and west codes to a quarter, half and three quarter turn.
module fixed_point_bearing_atan2_unit import bat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bat_in_if.sink      offset,
  bat_out_if.source   result
);

  // Direction registers. Writes must arrive only while the pipeline is empty; the
  // block does not enforce this. The output stage reads them directly.
  bat_codes_t codes;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.east <= EAST_RESET;
      codes.south <= SOUTH_RESET;
      codes.west <= WEST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        IDX_EAST:  codes.east <= cfg_data;
        IDX_SOUTH: codes.south <= cfg_data;
        IDX_WEST:  codes.west <= cfg_data;
        default:   codes <= codes;
      endcase
    end
  end

  // The whole pipeline moves together. It advances whenever the output register
  // is empty or its transaction is being taken, so an item can enter every cycle.
  logic        advance;
  logic        out_valid;
  logic [15:0] out_bearing;

  assign advance = !out_valid || result.ready;
  assign offset.ready = advance;
  assign result.valid = out_valid;
  assign result.bearing = out_bearing;

  // Index zero of these arrays is the preparation stage; the rest are divider stages.
  logic     div_valid [0:DIV_STAGES];
  bat_ctl_t div_ctl   [0:DIV_STAGES];
  bat_div_t div_st    [0:DIV_STAGES];

  bat_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .valid_in (offset.valid),
    .delta_x  (offset.delta_x),
    .delta_y  (offset.delta_y),
    .valid    (div_valid[0]),
    .ctl      (div_ctl[0]),
    .div      (div_st[0])
  );

  // The quotient of the smaller magnitude times 2^14 over the larger one is
  // resolved three bits per stage, most significant bit first.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    bat_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .valid_in (div_valid[s]),
      .ctl_in   (div_ctl[s]),
      .div_in   (div_st[s]),
      .valid    (div_valid[s+1]),
      .ctl      (div_ctl[s+1]),
      .div      (div_st[s+1])
    );
  end

  logic        poly_valid;
  bat_ctl_t    poly_ctl;
  logic [15:0] poly_angle;

  bat_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .valid_in (div_valid[DIV_STAGES]),
    .ctl_in   (div_ctl[DIV_STAGES]),
    .quo_in   (div_st[DIV_STAGES].quo),
    .valid    (poly_valid),
    .ctl      (poly_ctl),
    .angle    (poly_angle)
  );

  // Offsets on an axis skip the arctangent result here and take zero for north
  // or their direction code; all others fold into their octant with wrapping sums.
  bat_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .valid_in (poly_valid),
    .ctl_in   (poly_ctl),
    .angle    (poly_angle),
    .codes    (codes),
    .valid    (out_valid),
    .bearing  (out_bearing)
  );

endmodule

// ----- sv/bat_checker.sv -----
// Port-level checker for the bearing unit and the bind that attaches it.
module bat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] bearing
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its bearing.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(bearing))
    else $error("bearing changed while stalled");

  // The input is held off only while a finished result waits downstream.
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind fixed_point_bearing_atan2_unit bat_checker u_bat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (offset.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .bearing   (result.bearing)
);

// ----- verif/bearing_check.sv -----
// Bearing checker: predicts each bearing from the observed offsets and compares results.
module bearing_check import bat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bat_in_if           offset,
  bat_out_if          result,
  output int          failures,
  output int          outstanding
);

  typedef struct {
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] bearing;
  } bearing_entry_t;

  bat_codes_t     codes;
  bearing_entry_t pending_bearings[$];

  // Bit-exact bearing of one offset pair under the given direction codes.
  function automatic logic [15:0] predict_bearing(input logic [15:0] raw_x,
                                                  input logic [15:0] raw_y,
                                                  input bat_codes_t c);
    int          dx;
    int          dy;
    int          ax;
    int          ay;
    int          q;
    int          diff;
    int          corr;
    int          angle;
    logic        swapped;
    logic [15:0] a;
    dx = int'($signed(raw_x));
    dy = int'($signed(raw_y));
    if (dx == -32768) dx = -32767;
    if (dy == -32768) dy = -32767;
    if (dx == 0) return (dy > 0) ? 16'd0 : c.south;
    if (dy == 0) return (dx > 0) ? c.east : c.west;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    swapped = (ax > ay);
    q = swapped ? (ay << Q_SHIFT) / ax : (ax << Q_SHIFT) / ay;
    diff = (q > int'(ATAN_MID)) ? q - int'(ATAN_MID) : int'(ATAN_MID) - q;
    corr = (diff * int'(ATAN_K)) >>> Q_SHIFT;
    angle = ((int'(ATAN_C0) - corr) * q) >>> Q_SHIFT;
    a = angle[15:0];
    if (dx > 0) begin
      if (dy > 0) return swapped ? c.east - a : a;
      return swapped ? c.east + a : c.south - a;
    end
    if (dy > 0) return swapped ? c.west + a : 16'd0 - a;
    return swapped ? c.west - a : c.south + a;
  endfunction

  task automatic report_mismatch(input string msg);
    if (failures < 100) $display("bearing check error: %s", msg);
    failures++;
  endtask

  always @(posedge clk) begin
    bearing_entry_t oldest;
    if (rst) begin
      codes = '{east: EAST_RESET, south: SOUTH_RESET, west: WEST_RESET};
      pending_bearings.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          IDX_EAST:  codes.east = cfg_data;
          IDX_SOUTH: codes.south = cfg_data;
          IDX_WEST:  codes.west = cfg_data;
          default:   ;
        endcase
      end
      if (offset.valid && offset.ready) begin
        pending_bearings.push_back('{dx: offset.delta_x, dy: offset.delta_y,
            bearing: predict_bearing(offset.delta_x, offset.delta_y, codes)});
      end
      if (result.valid && result.ready) begin
        if (pending_bearings.size() == 0) begin
          report_mismatch($sformatf("unexpected bearing %0d", result.bearing));
        end else begin
          oldest = pending_bearings.pop_front();
          if (result.bearing !== oldest.bearing) begin
            report_mismatch($sformatf("dx=%0d dy=%0d bearing %0d, predicted %0d",
                $signed(oldest.dx), $signed(oldest.dy), result.bearing,
                oldest.bearing));
          end
        end
      end
      outstanding <= pending_bearings.size();
    end
  end

endmodule

// ----- verif/tb_fixed_point_bearing_atan2_unit.sv -----
// Testbench top for the bearing unit: stimulus, idling control, timeout and verdict.
module tb_fixed_point_bearing_atan2_unit;
  import bat_pkg::*;

  // The hold-off outlasts the unit's pipeline, so it covers any transaction
  // still in flight once the checker has nothing pending.
  localparam int SETTLE_CYCLES = 20;
  // The limit is far above what the slowest phase needs.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 100;

  // Directed offsets, dx in the upper half and dy in the lower half. They
  // cover the axis cases, the most negative value on both fields, equal
  // magnitudes and every octant with and without the swap.
  localparam logic [31:0] DIRECTED_OFFSETS [25] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0000_7FFF, 32'h0000_8000,
    32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_7FFF,
    32'h8000_8000, 32'h7FFF_8001, 32'h8001_7FFF, 32'h0001_0001, 32'h0001_FFFF,
    32'hFFFF_0001, 32'hFFFF_FFFF, 32'h0001_7FFF, 32'h7FFF_0001, 32'h8000_0001,
    32'h0001_8000, 32'h0064_FFDB, 32'hEC78_4E20, 32'h3039_A460, 32'h8001_FFFF
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          failures;
  int          outstanding;
  int          cycle_count;
  int          gap_pct;
  int          stall_pct;

  bat_in_if  offset_ch();
  bat_out_if result_ch();

  fixed_point_bearing_atan2_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .offset   (offset_ch),
    .result   (result_ch)
  );

  bearing_check check_bearings (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .offset     (offset_ch),
    .result     (result_ch),
    .failures   (failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The output side lowers ready at random, with a probability set per phase.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // A hung pipeline or a lost transaction ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Presents one offset and returns at the edge where the transaction is
  // accepted. Valid stays high afterward, so back-to-back transactions never
  // drop it; an idle cycle lowers it and drives junk on the payload.
  task automatic send_offset(input logic [15:0] dx, input logic [15:0] dy);
    while ($urandom_range(99, 0) < gap_pct) begin
      offset_ch.valid   <= 1'b0;
      offset_ch.delta_x <= 16'($urandom);
      offset_ch.delta_y <= 16'($urandom);
      @(posedge clk);
    end
    offset_ch.valid   <= 1'b1;
    offset_ch.delta_x <= dx;
    offset_ch.delta_y <= dy;
    @(posedge clk);
    while (!offset_ch.ready) @(posedge clk);
  endtask

  // Stops the sender and waits until every predicted bearing has arrived,
  // then lets the pipeline settle before anything else happens.
  task automatic drain_bearings();
    offset_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three direction codes, then the unused index with junk data,
  // which the unit must ignore. The enable stays high across the burst.
  task automatic load_codes(input logic [15:0] east, input logic [15:0] south,
                            input logic [15:0] west);
    cfg_we    <= 1'b1;
    cfg_index <= IDX_EAST;
    cfg_data  <= east;
    @(posedge clk);
    cfg_index <= IDX_SOUTH;
    cfg_data  <= south;
    @(posedge clk);
    cfg_index <= IDX_WEST;
    cfg_data  <= west;
    @(posedge clk);
    cfg_index <= 2'd3;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A single offset field, weighted toward zero and the extreme values so
  // that the axis cases and saturation come up often.
  function automatic logic [15:0] random_field();
    case ($urandom_range(9, 0))
      0: return 16'h0000;
      1: begin
        case ($urandom_range(4, 0))
          0: return 16'h8000;
          1: return 16'h8001;
          2: return 16'h7FFF;
          3: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // One phase: new direction codes, new idling, a run of random offsets and
  // a full drain at the end so the next configuration lands on an idle unit.
  task automatic run_phase(input logic [15:0] east, input logic [15:0] south,
                           input logic [15:0] west, input int sender_gap,
                           input int receiver_stall);
    logic [15:0] dx;
    logic [15:0] dy;
    load_codes(east, south, west);
    gap_pct   = sender_gap;
    stall_pct = receiver_stall;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      dx = random_field();
      dy = random_field();
      // Equal magnitudes hit the boundary between swapped and unswapped.
      if ($urandom_range(9, 0) == 0) dy = $urandom_range(1, 0) ? dx : 16'd0 - dx;
      send_offset(dx, dy);
    end
    drain_bearings();
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = IDX_EAST;
    cfg_data          = 16'h0000;
    offset_ch.valid   = 1'b0;
    offset_ch.delta_x = 16'h0000;
    offset_ch.delta_y = 16'h0000;
    gap_pct           = 0;
    stall_pct         = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed offsets run on the reset codes, before any write.
    foreach (DIRECTED_OFFSETS[i]) begin
      send_offset(DIRECTED_OFFSETS[i][31:16], DIRECTED_OFFSETS[i][15:0]);
    end
    drain_bearings();

    // Code extremes, then random codes, then back to the reset values. The
    // idling moves from none, to a slow sender, to a slow receiver, to both.
    run_phase(16'h0000, 16'h0000, 16'h0000, 0, 0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 81, 0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 0, 81);
    run_phase(EAST_RESET, SOUTH_RESET, WEST_RESET, 17, 17);

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bat_pkg.sv
sv/bat_if.sv
sv/bat_prep.sv
sv/bat_div_stage.sv
sv/bat_poly.sv
sv/bat_fold.sv
sv/fixed_point_bearing_atan2_unit.sv
sv/bat_checker.sv
verif/bearing_check.sv
verif/tb_fixed_point_bearing_atan2_unit.sv
